// ===== rtl/h2r_pkg.sv =====
// shared constants for the hsv/hsl to rgb converter
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

    // pipeline depth, one enable per register stage
    localparam int unsigned NSTAGE = 8;

    // hue is in 1/16 degree
    localparam int unsigned HUE_TURN   = 5760;
    localparam int unsigned HUE_SECTOR = 960;
    localparam int unsigned HALF_SECTOR = HUE_SECTOR / 2;
    localparam int unsigned FULL_SCALE = 255;

    // channels are numerators over 2*255*960
    localparam int unsigned CH_DENOM = 2 * FULL_SCALE * HUE_SECTOR;
    localparam int unsigned CH_HALF  = CH_DENOM / 2;

    // reciprocals for the divides by constants, rounded up
    localparam int unsigned HUE_SHIFT = 29;
    localparam int unsigned SEC_SHIFT = 23;
    localparam int unsigned CH_SHIFT  = 46;
    localparam logic [16:0] HUE_RECIP =
        17'(((64'd1 << HUE_SHIFT) + 64'(HUE_TURN) - 64'd1) / 64'(HUE_TURN));
    localparam logic [13:0] SEC_RECIP =
        14'(((64'd1 << SEC_SHIFT) + 64'(HUE_SECTOR) - 64'd1) / 64'(HUE_SECTOR));
    localparam logic [27:0] CH_RECIP =
        28'(((64'd1 << CH_SHIFT) + 64'(CH_DENOM) - 64'd1) / 64'(CH_DENOM));

    // input model codes
    localparam logic MODEL_HSV = 1'b0;
    localparam logic MODEL_HSL = 1'b1;

    typedef logic [NSTAGE-1:0] stage_vec_t;

endpackage

`default_nettype wire

// ===== rtl/h2r_pipe_ctrl.sv =====
// valid bits and per-stage load enables for the converter pipeline
`timescale 1ns / 1ps
`default_nettype none

module h2r_pipe_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output h2r_pkg::stage_vec_t  stage_en,
    output h2r_pkg::stage_vec_t  stage_valid
);

    h2r_pkg::stage_vec_t valid_reg;
    h2r_pkg::stage_vec_t valid_next;
    logic [h2r_pkg::NSTAGE:0] ready;
    h2r_pkg::stage_vec_t feed;

    // a stage can load when it is empty or its word moves on
    always_comb begin
        ready[h2r_pkg::NSTAGE] = out_ready;
        for (int k = h2r_pkg::NSTAGE - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        feed[0] = in_valid;
        for (int k = 1; k < h2r_pkg::NSTAGE; k++) begin
            feed[k] = valid_reg[k-1];
        end
        for (int k = 0; k < h2r_pkg::NSTAGE; k++) begin
            stage_en[k]   = ready[k] && feed[k];
            valid_next[k] = ready[k] ? feed[k] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready    = ready[0];
    assign out_valid   = valid_reg[h2r_pkg::NSTAGE-1];
    assign stage_valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/h2r_hue_sector.sv =====
// hue wrap, sector pick and position within the sector (stages 0 to 3)
`timescale 1ns / 1ps
`default_nettype none

module h2r_hue_sector (
    input  wire                  aclk,
    input  h2r_pkg::stage_vec_t  stage_en,
    input  wire [15:0]           hue_angle,
    input  wire                  hue_undefined,
    output logic [2:0]           sector_s3,
    output logic [10:0]          frac_s3,
    output logic                 undef_s3
);

    logic [3:0]  turn_s0_reg, turn_s0_next;
    logic [15:0] hue_s0_reg;
    logic        undef_s0_reg, undef_s1_reg, undef_s2_reg, undef_s3_reg;
    logic [12:0] wrap_s1_reg, wrap_s1_next;
    logic [12:0] wrap_s2_reg;
    logic [2:0]  sector_s2_reg, sector_s2_next;
    logic [2:0]  sector_s3_reg;
    logic [10:0] frac_s3_reg, frac_s3_next;
    logic [32:0] turn_prod;
    logic [25:0] sector_prod;
    logic [9:0]  pos;

    always_comb begin
        turn_prod    = 33'(hue_angle) * 33'(h2r_pkg::HUE_RECIP);
        turn_s0_next = turn_prod[32:h2r_pkg::HUE_SHIFT];

        wrap_s1_next = 13'(hue_s0_reg - 16'(16'(turn_s0_reg) * 16'(h2r_pkg::HUE_TURN)));

        sector_prod    = 26'(wrap_s1_reg) * 26'(h2r_pkg::SEC_RECIP);
        sector_s2_next = sector_prod[25:h2r_pkg::SEC_SHIFT];

        // odd sectors run the ramp downward
        pos = 10'(wrap_s2_reg - 13'(13'(sector_s2_reg) * 13'(h2r_pkg::HUE_SECTOR)));
        if (sector_s2_reg[0]) begin
            frac_s3_next = 11'(h2r_pkg::HUE_SECTOR) - {1'b0, pos};
        end else begin
            frac_s3_next = {1'b0, pos};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            turn_s0_reg  <= turn_s0_next;
            hue_s0_reg   <= hue_angle;
            undef_s0_reg <= hue_undefined;
        end
        if (stage_en[1]) begin
            wrap_s1_reg  <= wrap_s1_next;
            undef_s1_reg <= undef_s0_reg;
        end
        if (stage_en[2]) begin
            wrap_s2_reg   <= wrap_s1_reg;
            sector_s2_reg <= sector_s2_next;
            undef_s2_reg  <= undef_s1_reg;
        end
        if (stage_en[3]) begin
            sector_s3_reg <= sector_s2_reg;
            frac_s3_reg   <= frac_s3_next;
            undef_s3_reg  <= undef_s2_reg;
        end
    end

    assign sector_s3 = sector_s3_reg;
    assign frac_s3   = frac_s3_reg;
    assign undef_s3  = undef_s3_reg;

endmodule

`default_nettype wire

// ===== rtl/h2r_chroma.sv =====
// chroma and offset numerators for hsv or hsl (stages 0 to 3)
`timescale 1ns / 1ps
`default_nettype none

module h2r_chroma (
    input  wire                  aclk,
    input  h2r_pkg::stage_vec_t  stage_en,
    input  wire                  model_select,
    input  wire [7:0]            sat_level,
    input  wire [7:0]            value_or_light,
    output logic [16:0]          cq_s3,
    output logic [26:0]          cn_s3,
    output logic [26:0]          mn_s3
);

    logic [16:0] cq_s0_reg, cq_s0_next;
    logic [7:0]  level_s0_reg;
    logic        model_s0_reg;
    logic [16:0] cq_s1_reg, cq_s2_reg, cq_s3_reg;
    logic [26:0] cn_s1_reg, cn_s1_next, cn_s2_reg, cn_s3_reg;
    logic [26:0] mn_s1_reg, mn_s1_next, mn_s2_reg, mn_s3_reg;
    logic [8:0]  twice;
    logic [8:0]  lvl_dev;
    logic [7:0]  span;
    logic [7:0]  sel;
    logic [15:0] sv_prod;

    always_comb begin
        // hsl chroma scale is 255 - |2L - 255|
        twice = {value_or_light, 1'b0};
        if (twice >= 9'(h2r_pkg::FULL_SCALE)) begin
            lvl_dev = twice - 9'(h2r_pkg::FULL_SCALE);
        end else begin
            lvl_dev = 9'(h2r_pkg::FULL_SCALE) - twice;
        end
        span = 8'(9'(h2r_pkg::FULL_SCALE) - lvl_dev);
        sel  = (model_select == h2r_pkg::MODEL_HSL) ? span : value_or_light;
        sv_prod    = 16'(sat_level) * 16'(sel);
        cq_s0_next = {sv_prod, 1'b0};

        cn_s1_next = 27'(cq_s0_reg * 27'(h2r_pkg::HUE_SECTOR));
        if (model_s0_reg == h2r_pkg::MODEL_HSL) begin
            mn_s1_next = 27'(27'(level_s0_reg) * 27'(h2r_pkg::CH_DENOM))
                       - 27'(cq_s0_reg * 27'(h2r_pkg::HALF_SECTOR));
        end else begin
            mn_s1_next = 27'(27'(level_s0_reg) * 27'(h2r_pkg::CH_DENOM))
                       - 27'(cq_s0_reg * 27'(h2r_pkg::HUE_SECTOR));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            cq_s0_reg    <= cq_s0_next;
            level_s0_reg <= value_or_light;
            model_s0_reg <= model_select;
        end
        if (stage_en[1]) begin
            cq_s1_reg <= cq_s0_reg;
            cn_s1_reg <= cn_s1_next;
            mn_s1_reg <= mn_s1_next;
        end
        if (stage_en[2]) begin
            cq_s2_reg <= cq_s1_reg;
            cn_s2_reg <= cn_s1_reg;
            mn_s2_reg <= mn_s1_reg;
        end
        if (stage_en[3]) begin
            cq_s3_reg <= cq_s2_reg;
            cn_s3_reg <= cn_s2_reg;
            mn_s3_reg <= mn_s2_reg;
        end
    end

    assign cq_s3 = cq_s3_reg;
    assign cn_s3 = cn_s3_reg;
    assign mn_s3 = mn_s3_reg;

endmodule

`default_nettype wire

// ===== rtl/h2r_mix.sv =====
// intermediate term, channel sums, rounding divide and clamp (stages 4 to 7)
`timescale 1ns / 1ps
`default_nettype none

module h2r_mix (
    input  wire                  aclk,
    input  h2r_pkg::stage_vec_t  stage_en,
    input  wire [2:0]            sector_s3,
    input  wire [10:0]           frac_s3,
    input  wire                  undef_s3,
    input  wire [16:0]           cq_s3,
    input  wire [26:0]           cn_s3,
    input  wire [26:0]           mn_s3,
    output logic [7:0]           red_out,
    output logic [7:0]           green_out,
    output logic [7:0]           blue_out
);

    logic [26:0] xn_s4_reg, xn_s4_next;
    logic [26:0] cn_s4_reg, mn_s4_reg;
    logic [2:0]  sector_s4_reg;
    logic        undef_s4_reg;
    logic [26:0] chan_s5_reg [3];
    logic [26:0] chan_s5_next [3];
    logic [54:0] prod_s6_reg [3];
    logic [54:0] prod_s6_next [3];
    logic [7:0]  out_s7_reg [3];
    logic [7:0]  out_s7_next [3];
    logic [26:0] add_r, add_g, add_b;
    logic [8:0]  quot [3];

    always_comb begin
        xn_s4_next = 27'(28'(cq_s3) * 28'(frac_s3));

        add_r = '0;
        add_g = '0;
        add_b = '0;
        if (!undef_s4_reg) begin
            case (sector_s4_reg)
                3'd0: begin
                    add_r = cn_s4_reg;
                    add_g = xn_s4_reg;
                end
                3'd1: begin
                    add_r = xn_s4_reg;
                    add_g = cn_s4_reg;
                end
                3'd2: begin
                    add_g = cn_s4_reg;
                    add_b = xn_s4_reg;
                end
                3'd3: begin
                    add_g = xn_s4_reg;
                    add_b = cn_s4_reg;
                end
                3'd4: begin
                    add_r = xn_s4_reg;
                    add_b = cn_s4_reg;
                end
                default: begin
                    add_r = cn_s4_reg;
                    add_b = xn_s4_reg;
                end
            endcase
        end
        // half the denominator added here for round to nearest
        chan_s5_next[0] = mn_s4_reg + add_r + 27'(h2r_pkg::CH_HALF);
        chan_s5_next[1] = mn_s4_reg + add_g + 27'(h2r_pkg::CH_HALF);
        chan_s5_next[2] = mn_s4_reg + add_b + 27'(h2r_pkg::CH_HALF);

        for (int c = 0; c < 3; c++) begin
            prod_s6_next[c] = 55'(chan_s5_reg[c]) * 55'(h2r_pkg::CH_RECIP);
            quot[c] = prod_s6_reg[c][54:h2r_pkg::CH_SHIFT];
            out_s7_next[c] = (quot[c] > 9'(h2r_pkg::FULL_SCALE)) ?
                             8'(h2r_pkg::FULL_SCALE) : quot[c][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            xn_s4_reg     <= xn_s4_next;
            cn_s4_reg     <= cn_s3;
            mn_s4_reg     <= mn_s3;
            sector_s4_reg <= sector_s3;
            undef_s4_reg  <= undef_s3;
        end
        if (stage_en[5]) begin
            chan_s5_reg <= chan_s5_next;
        end
        if (stage_en[6]) begin
            prod_s6_reg <= prod_s6_next;
        end
        if (stage_en[7]) begin
            out_s7_reg <= out_s7_next;
        end
    end

    assign red_out   = out_s7_reg[0];
    assign green_out = out_s7_reg[1];
    assign blue_out  = out_s7_reg[2];

endmodule

`default_nettype wire

// ===== rtl/hsv_hsl_to_rgb_convert.sv =====
// Converts one HSV or HSL pixel per clock to 8-bit RGB while neither side stalls.
// Hue is in 1/16 degree and wraps modulo 360 degrees; saturation and value or
// lightness are fractions of 255; cfg_wr_data selects HSL (1) or HSV (0) and the
// user must write it with cfg_wr_en only while no pixel is in flight; the block
// itself does not enforce this. An undefined hue (tuser set) gives gray. The
// datapath is an 8-stage pipeline, and one pixel enters every cycle while the
// pipeline has room. Each stage keeps its own valid bit, so a stall on the
// output fills bubbles before it holds the input.
`timescale 1ns / 1ps
`default_nettype none

module hsv_hsl_to_rgb_convert (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire          cfg_wr_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // hue_angle, sat_level, value_or_light
    input  wire          s_axis_tuser,   // hue_undefined
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [23:0]  m_axis_tdata    // red_out, green_out, blue_out
);

    logic                model_select_reg;
    h2r_pkg::stage_vec_t stage_en;
    h2r_pkg::stage_vec_t stage_valid;
    logic [2:0]          sector_s3;
    logic [10:0]         frac_s3;
    logic                undef_s3;
    logic [16:0]         cq_s3;
    logic [26:0]         cn_s3;
    logic [26:0]         mn_s3;
    logic [7:0]          red_out, green_out, blue_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_select_reg <= h2r_pkg::MODEL_HSV;
        end else if (cfg_wr_en) begin
            model_select_reg <= cfg_wr_data;
        end
    end

    h2r_pipe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .stage_en    (stage_en),
        .stage_valid (stage_valid)
    );

    h2r_hue_sector u_hue (
        .aclk          (aclk),
        .stage_en      (stage_en),
        .hue_angle     (s_axis_tdata[15:0]),
        .hue_undefined (s_axis_tuser),
        .sector_s3     (sector_s3),
        .frac_s3       (frac_s3),
        .undef_s3      (undef_s3)
    );

    h2r_chroma u_chroma (
        .aclk           (aclk),
        .stage_en       (stage_en),
        .model_select   (model_select_reg),
        .sat_level      (s_axis_tdata[23:16]),
        .value_or_light (s_axis_tdata[31:24]),
        .cq_s3          (cq_s3),
        .cn_s3          (cn_s3),
        .mn_s3          (mn_s3)
    );

    h2r_mix u_mix (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .sector_s3 (sector_s3),
        .frac_s3   (frac_s3),
        .undef_s3  (undef_s3),
        .cq_s3     (cq_s3),
        .cn_s3     (cn_s3),
        .mn_s3     (mn_s3),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    assign m_axis_tdata = {blue_out, green_out, red_out};

    // input only backs up when every stage is full and the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (stage_valid == '1) && !m_axis_tready)
        else $error("input stalled while pipeline has room");

    // a word behind the output moves up when the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && stage_valid[h2r_pkg::NSTAGE-2]
        |=> m_axis_tvalid)
        else $error("word lost between last two stages");

    // an accepted word is held in the first stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> stage_valid[0])
        else $error("accepted word missing from first stage");

endmodule

`default_nettype wire

// ===== tb/sv/hsv_hsl_to_rgb_check.sv =====
// checker for the hsv/hsl to rgb converter: predicts each pixel and compares the output words
`timescale 1ns / 1ps
`default_nettype none

module hsv_hsl_to_rgb_check (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire          cfg_wr_data,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // hue_angle, sat_level, value_or_light
    input  wire          s_axis_tuser,   // hue_undefined
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire  [23:0]  m_axis_tdata,   // red_out, green_out, blue_out
    output int           mismatches,
    output int           rgb_pending
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    rgb_t rgb_due[$];
    logic hsl_mode;
    int   fail_count;

    function automatic logic [7:0] round_channel(input int unsigned num);
        int unsigned q;
        q = (num + h2r_pkg::CH_HALF) / h2r_pkg::CH_DENOM;
        if (q > h2r_pkg::FULL_SCALE) begin
            q = h2r_pkg::FULL_SCALE;
        end
        return q[7:0];
    endfunction

    function automatic rgb_t convert_pixel(input logic hsl, input logic [15:0] hue,
                                           input logic undef, input logic [7:0] sat,
                                           input logic [7:0] lvl);
        int unsigned h, sector, frac, cq, cn, mn, xn, twice, lvl_dev, span;
        int unsigned r, g, b;
        rgb_t px;
        h      = int'(hue) % h2r_pkg::HUE_TURN;
        sector = h / h2r_pkg::HUE_SECTOR;
        frac   = h % h2r_pkg::HUE_SECTOR;
        if (hsl == h2r_pkg::MODEL_HSV) begin
            cq = 2 * sat * lvl;
            cn = cq * h2r_pkg::HUE_SECTOR;
            mn = h2r_pkg::CH_DENOM * lvl - cn;
        end else begin
            twice   = 2 * lvl;
            lvl_dev = (twice >= h2r_pkg::FULL_SCALE) ? twice - h2r_pkg::FULL_SCALE
                                                     : h2r_pkg::FULL_SCALE - twice;
            span    = h2r_pkg::FULL_SCALE - lvl_dev;
            cq      = 2 * sat * span;
            cn      = cq * h2r_pkg::HUE_SECTOR;
            mn      = h2r_pkg::CH_DENOM * lvl - cn / 2;
        end
        r = mn;
        g = mn;
        b = mn;
        // gray pixel: every channel stays at m
        if (!undef) begin
            xn = sector[0] ? cq * (h2r_pkg::HUE_SECTOR - frac) : cq * frac;
            case (sector)
                0: begin r += cn; g += xn; end
                1: begin r += xn; g += cn; end
                2: begin g += cn; b += xn; end
                3: begin g += xn; b += cn; end
                4: begin r += xn; b += cn; end
                default: begin r += cn; b += xn; end
            endcase
        end
        px.red   = round_channel(r);
        px.green = round_channel(g);
        px.blue  = round_channel(b);
        return px;
    endfunction

    always @(posedge aclk) begin
        rgb_t want, got;
        if (!aresetn) begin
            hsl_mode = h2r_pkg::MODEL_HSV;
            rgb_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (rgb_due.size() == 0) begin
                    $error("output word %h with no pixel waiting", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rgb_due.push_back(convert_pixel(hsl_mode, s_axis_tdata[15:0], s_axis_tuser,
                                                s_axis_tdata[23:16], s_axis_tdata[31:24]));
            end
            // mode only changes while idle, so it applies from the next word on
            if (cfg_wr_en) begin
                hsl_mode = cfg_wr_data;
            end
        end
        mismatches  <= fail_count;
        rgb_pending <= rgb_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsv_hsl_to_rgb_convert.sv =====
// testbench top for the hsv/hsl to rgb converter: clock, reset, pixel stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_hsv_hsl_to_rgb_convert;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE      = h2r_pkg::NSTAGE + 4;
    localparam int unsigned RAND_PHASE  = 163;
    localparam int unsigned CALM_ITEMS  = 30;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic         cfg_wr_data   = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;    // hue_angle, sat_level, value_or_light
    logic         s_axis_tuser  = 1'b0;  // hue_undefined
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [23:0]  m_axis_tdata;          // red_out, green_out, blue_out

    int           mismatches;
    int           rgb_pending;
    logic         calm = 1'b0;
    int unsigned  stall_left = 0;
    int unsigned  cycles = 0;

    always #1 aclk = ~aclk;

    hsv_hsl_to_rgb_convert i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hsv_hsl_to_rgb_check i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .rgb_pending   (rgb_pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] pick_level();
        logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 5) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_hue();
        int unsigned r;
        int unsigned offs[4] = '{0, 1, h2r_pkg::HALF_SECTOR, h2r_pkg::HUE_SECTOR - 1};
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 16'($urandom_range(0, h2r_pkg::HUE_TURN - 1));
        end else if (r < 8) begin
            return 16'($urandom_range(0, 5) * h2r_pkg::HUE_SECTOR + offs[$urandom_range(0, 3)]);
        end else if (r == 8) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(h2r_pkg::HUE_TURN, 65535));
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_hsv_hsl_to_rgb_convert: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] hue, input logic undef,
                              input logic [7:0] sat, input logic [7:0] lvl);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= {lvl, sat, hue};
        s_axis_tuser  <= undef;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // hold off the sender until every pixel in flight has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (rgb_pending != 0) @(posedge aclk);
    endtask

    task automatic set_model(input logic hsl);
        drain();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hsl;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic modes[4] = '{h2r_pkg::MODEL_HSV, h2r_pkg::MODEL_HSL,
                           h2r_pkg::MODEL_HSV, h2r_pkg::MODEL_HSL};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hsv after reset: primaries, sector edges, wrap, gray cases
        send_pixel(16'd0,     1'b0, 8'd255, 8'd255);
        send_pixel(16'd959,   1'b0, 8'd255, 8'd255);
        send_pixel(16'd960,   1'b0, 8'd255, 8'd255);
        send_pixel(16'd1920,  1'b0, 8'd255, 8'd200);
        send_pixel(16'd2880,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd3840,  1'b0, 8'd170, 8'd255);
        send_pixel(16'd4800,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd5759,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd5760,  1'b0, 8'd255, 8'd255);
        send_pixel(16'hffff,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd1000,  1'b1, 8'd255, 8'd200);
        send_pixel(16'd2000,  1'b0, 8'd0,   8'd255);
        send_pixel(16'd3000,  1'b0, 8'd255, 8'd0);
        send_pixel(16'd480,   1'b0, 8'd128, 8'd128);

        // hsl: lightness around the midpoint and at both ends
        set_model(h2r_pkg::MODEL_HSL);
        send_pixel(16'd0,     1'b0, 8'd255, 8'd128);
        send_pixel(16'd0,     1'b0, 8'd255, 8'd127);
        send_pixel(16'd1500,  1'b0, 8'd255, 8'd0);
        send_pixel(16'd4000,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd2400,  1'b0, 8'd255, 8'd64);
        send_pixel(16'd4321,  1'b0, 8'd1,   8'd200);
        send_pixel(16'd700,   1'b1, 8'd255, 8'd100);
        send_pixel(16'd5000,  1'b0, 8'd0,   8'd77);
        send_pixel(16'hffff,  1'b0, 8'd255, 8'd255);
        send_pixel(16'd3000,  1'b0, 8'd200, 8'd192);

        foreach (modes[p]) begin
            set_model(modes[p]);
            for (int i = 0; i < RAND_PHASE; i++) begin
                calm = (i < CALM_ITEMS);
                send_pixel(pick_hue(), ($urandom_range(0, 7) == 0), pick_level(), pick_level());
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end
            end
            calm = 1'b0;
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_hsv_hsl_to_rgb_convert: done, clean");
        end else begin
            $display("tb_hsv_hsl_to_rgb_convert: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/h2r_pkg.sv
rtl/h2r_pipe_ctrl.sv
rtl/h2r_hue_sector.sv
rtl/h2r_chroma.sv
rtl/h2r_mix.sv
rtl/hsv_hsl_to_rgb_convert.sv
tb/sv/hsv_hsl_to_rgb_check.sv
tb/sv/tb_hsv_hsl_to_rgb_convert.sv
